// ===== sv/md5s_pkg.sv =====
// Shared types, round constants and index helpers for the MD5 stream hash core.
package md5s_pkg;

    localparam int WORDS      = 16;
    localparam int WORD_AW    = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_CMP_INIT,
        ST_CMP_RUN,
        ST_CMP_ADD,
        ST_DONE
    } md5s_state_t;

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = r[3:0];
        unique case (r[5:4])
            2'd0: idx = lo;
            2'd1: idx = 4'(lo << 2) + lo + 4'd1;
            2'd2: idx = 4'(lo << 1) + lo + 4'd5;
            default: idx = 4'(lo << 3) - lo;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

// ===== sv/md5s_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module md5s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/md5s_round.sv =====
// One MD5 round step: computes the new B word from the working words and message word.
module md5s_round (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] w,
    input  logic [5:0]  round,
    output logic [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] sum;

    always_comb
    begin
        unique case (round[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
    end

    assign sum   = a + f + md5s_pkg::ROUND_ADD[round] + w;
    assign b_new = b + md5s_pkg::rotl32(sum, md5s_pkg::ROT_AMT[{round[5:4], round[1:0]}]);

endmodule

// ===== sv/md5_stream_hash_core.sv =====
// MD5 stream hash core: byte intake, padding, block compression and digest output.
// Items are accepted back to back in the load state while a block fills; each full 64-byte
// block is then compressed (init, 64 rounds, chaining add) with input held.
// Finishing a message, with input also held, writes the padding bytes into the buffer,
// compresses each padded block, then loads the digest register. Reset clears all control
// state and loads the MD5 initial chaining words; the block buffer RAM is not cleared.
module md5_stream_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_first,
    output logic [63:0] digest_second
);

    // Byte swap: MD5 emits each chaining word least significant byte first.
    function automatic logic [31:0] bswap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    md5s_pkg::md5s_state_t state_reg, state_next;
    md5s_pkg::md5s_state_t ret_reg, ret_next;

    // chaining words and working registers of the compression
    logic [31:0] chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic [31:0] chain_a_next, chain_b_next, chain_c_next, chain_d_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [5:0]  round_reg, round_next;

    // block fill position, message bit count and partial word (bytes 0..2)
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [23:0] acc_reg, acc_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] digest_first_reg, digest_first_next;
    logic [63:0] digest_second_reg, digest_second_next;

    // put-byte path into the block buffer
    logic        put_en;
    logic [7:0]  put_val;
    logic [2:0]  len_idx;

    // block buffer RAM: 16 little-endian message words
    logic                           ram_we;
    logic [md5s_pkg::WORD_AW-1:0]   ram_waddr;
    logic [31:0]                    ram_wdata;
    logic [md5s_pkg::WORD_AW-1:0]   ram_raddr;
    logic [31:0]                    ram_rdata;

    logic [31:0] round_b;
    logic        in_fire;
    logic        digest_load;

    md5s_ram #(
        .WIDTH (32),
        .DEPTH (md5s_pkg::WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5s_round u_round (
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .w     (ram_rdata),
        .round (round_reg),
        .b_new (round_b)
    );

    assign in_ready      = (state_reg == md5s_pkg::ST_LOAD);
    assign in_fire       = in_valid && in_ready;
    assign digest_load   = (state_reg == md5s_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign digest_first  = digest_first_reg;
    assign digest_second = digest_second_reg;
    assign len_idx       = pos_reg[2:0];

    // Next state and return point after a compression
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            md5s_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (has_byte && pos_reg == md5s_pkg::LAST_POS)
                    begin
                        state_next = md5s_pkg::ST_CMP_INIT;
                        ret_next   = last_item ? md5s_pkg::ST_PAD_MARK : md5s_pkg::ST_LOAD;
                    end
                    else if (last_item)
                    begin
                        state_next = md5s_pkg::ST_PAD_MARK;
                    end
                end
            end
            md5s_pkg::ST_PAD_MARK:
            begin
                if (pos_reg == md5s_pkg::LAST_POS)
                begin
                    state_next = md5s_pkg::ST_CMP_INIT;
                    ret_next   = md5s_pkg::ST_PAD_ZERO;
                end
                else
                begin
                    state_next = md5s_pkg::ST_PAD_ZERO;
                end
            end
            md5s_pkg::ST_PAD_ZERO:
            begin
                if (pos_reg == md5s_pkg::LEN_POS)
                begin
                    state_next = md5s_pkg::ST_PAD_LEN;
                end
                else if (pos_reg == md5s_pkg::LAST_POS)
                begin
                    state_next = md5s_pkg::ST_CMP_INIT;
                    ret_next   = md5s_pkg::ST_PAD_ZERO;
                end
            end
            md5s_pkg::ST_PAD_LEN:
            begin
                if (pos_reg == md5s_pkg::LAST_POS)
                begin
                    state_next = md5s_pkg::ST_CMP_INIT;
                    ret_next   = md5s_pkg::ST_DONE;
                end
            end
            md5s_pkg::ST_CMP_INIT:
            begin
                state_next = md5s_pkg::ST_CMP_RUN;
            end
            md5s_pkg::ST_CMP_RUN:
            begin
                if (round_reg == md5s_pkg::LAST_ROUND)
                begin
                    state_next = md5s_pkg::ST_CMP_ADD;
                end
            end
            md5s_pkg::ST_CMP_ADD:
            begin
                state_next = ret_reg;
            end
            md5s_pkg::ST_DONE:
            begin
                if (digest_load)
                begin
                    state_next = md5s_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = md5s_pkg::ST_LOAD;
            end
        endcase
    end

    // Byte source for the buffer: message byte, 0x80 mark, zero fill or length byte
    always_comb
    begin
        put_en  = 1'b0;
        put_val = 8'h00;
        unique case (state_reg)
            md5s_pkg::ST_LOAD:
            begin
                put_en  = in_fire && has_byte;
                put_val = data_byte;
            end
            md5s_pkg::ST_PAD_MARK:
            begin
                put_en  = 1'b1;
                put_val = md5s_pkg::PAD_MARK_BYTE;
            end
            md5s_pkg::ST_PAD_ZERO:
            begin
                put_en  = (pos_reg != md5s_pkg::LEN_POS);
                put_val = 8'h00;
            end
            md5s_pkg::ST_PAD_LEN:
            begin
                put_en  = 1'b1;
                put_val = 8'(bit_count_reg >> {len_idx, 3'b000});
            end
            default:
            begin
                put_en  = 1'b0;
                put_val = 8'h00;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        pos_next           = pos_reg;
        acc_next           = acc_reg;
        bit_count_next     = bit_count_reg;
        ram_we             = 1'b0;
        ram_waddr          = pos_reg[5:2];
        ram_wdata          = {put_val, acc_reg};
        ram_raddr          = md5s_pkg::msg_index(6'd0);
        a_next             = a_reg;
        b_next             = b_reg;
        c_next             = c_reg;
        d_next             = d_reg;
        round_next         = round_reg;
        chain_a_next       = chain_a_reg;
        chain_b_next       = chain_b_reg;
        chain_c_next       = chain_c_reg;
        chain_d_next       = chain_d_reg;
        out_valid_next     = out_valid_reg;
        digest_first_next  = digest_first_reg;
        digest_second_next = digest_second_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // assemble little-endian words, write on the fourth byte
        if (put_en)
        begin
            pos_next = pos_reg + 6'd1;
            unique case (pos_reg[1:0])
                2'd0: acc_next[7:0]   = put_val;
                2'd1: acc_next[15:8]  = put_val;
                2'd2: acc_next[23:16] = put_val;
                default: ram_we       = 1'b1;
            endcase
        end

        if (in_fire && has_byte)
        begin
            bit_count_next = bit_count_reg + 64'd8;
        end

        unique case (state_reg)
            md5s_pkg::ST_CMP_INIT:
            begin
                a_next     = chain_a_reg;
                b_next     = chain_b_reg;
                c_next     = chain_c_reg;
                d_next     = chain_d_reg;
                round_next = 6'd0;
                ram_raddr  = md5s_pkg::msg_index(6'd0);
            end
            md5s_pkg::ST_CMP_RUN:
            begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = round_b;
                round_next = round_reg + 6'd1;
                // prefetch the word for the next round
                ram_raddr  = md5s_pkg::msg_index(round_reg + 6'd1);
            end
            md5s_pkg::ST_CMP_ADD:
            begin
                chain_a_next = chain_a_reg + a_reg;
                chain_b_next = chain_b_reg + b_reg;
                chain_c_next = chain_c_reg + c_reg;
                chain_d_next = chain_d_reg + d_reg;
            end
            md5s_pkg::ST_DONE:
            begin
                if (digest_load)
                begin
                    out_valid_next     = 1'b1;
                    digest_first_next  = {bswap32(chain_a_reg), bswap32(chain_b_reg)};
                    digest_second_next = {bswap32(chain_c_reg), bswap32(chain_d_reg)};
                    chain_a_next       = md5s_pkg::IV_A;
                    chain_b_next       = md5s_pkg::IV_B;
                    chain_c_next       = md5s_pkg::IV_C;
                    chain_d_next       = md5s_pkg::IV_D;
                    bit_count_next     = 64'd0;
                    pos_next           = 6'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5s_pkg::ST_LOAD;
            ret_reg       <= md5s_pkg::ST_LOAD;
            pos_reg       <= 6'd0;
            bit_count_reg <= 64'd0;
            round_reg     <= 6'd0;
            chain_a_reg   <= md5s_pkg::IV_A;
            chain_b_reg   <= md5s_pkg::IV_B;
            chain_c_reg   <= md5s_pkg::IV_C;
            chain_d_reg   <= md5s_pkg::IV_D;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pos_reg       <= pos_next;
            bit_count_reg <= bit_count_next;
            round_reg     <= round_next;
            chain_a_reg   <= chain_a_next;
            chain_b_reg   <= chain_b_next;
            chain_c_reg   <= chain_c_next;
            chain_d_reg   <= chain_d_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        acc_reg           <= acc_next;
        a_reg             <= a_next;
        b_reg             <= b_next;
        c_reg             <= c_next;
        d_reg             <= d_next;
        digest_first_reg  <= digest_first_next;
        digest_second_reg <= digest_second_next;
    end

endmodule

// ===== tb/md5_stream_checker.sv =====
// Digest checker for the MD5 stream hash core: tracks input beats, predicts digests, compares.
module md5_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] digest_first,
    input  logic [63:0] digest_second,
    output int          fail_count,
    output int          digests_pending,
    output int          digests_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] first;
        logic [63:0] second;
    } digest_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_START = 8'h80;
    localparam int          LEN_FIELD_POS = 56;
    localparam int          BLOCK_BYTES = 64;
    localparam int          REPORT_LIMIT = 10;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // four shift amounts per 16-round group
    localparam logic [4:0] SHIFT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    logic [31:0] chain_q [4];
    logic [7:0]  block_q [BLOCK_BYTES];
    logic [63:0] msg_bits;
    int          fill_pos;
    digest_t     digest_fifo [$];

    function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic void start_message();
        chain_q[0] = INIT_A;
        chain_q[1] = INIT_B;
        chain_q[2] = INIT_C;
        chain_q[3] = INIT_D;
        msg_bits = '0;
        fill_pos = 0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, tmp;
        int          g;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_q[4*i+3], block_q[4*i+2], block_q[4*i+1], block_q[4*i]};
        end
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (int r = 0; r < 64; r++)
        begin
            case (r / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            tmp = d;
            d = c;
            c = b;
            b = b + rol32(a + f + ROUND_K[r] + w[g], SHIFT_AMT[(r / 16) * 4 + r % 4]);
            a = tmp;
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
    endfunction

    function automatic void put_byte(input logic [7:0] v);
        block_q[fill_pos] = v;
        fill_pos++;
        if (fill_pos == BLOCK_BYTES)
        begin
            compress_block();
            fill_pos = 0;
        end
    endfunction

    // one accepted input beat; pushes a digest when the beat closes a message
    function automatic void take_beat(input logic [7:0] b, input logic hb, input logic lst);
        logic [63:0] len_bits;
        digest_t     dg;
        if (hb)
        begin
            put_byte(b);
            msg_bits += 64'd8;
        end
        if (lst)
        begin
            len_bits = msg_bits;
            put_byte(PAD_START);
            while (fill_pos != LEN_FIELD_POS)
                put_byte(8'h00);
            for (int i = 0; i < 8; i++)
                put_byte(len_bits[8*i +: 8]);
            dg.first  = {swap32(chain_q[0]), swap32(chain_q[1])};
            dg.second = {swap32(chain_q[2]), swap32(chain_q[3])};
            digest_fifo.push_back(dg);
            start_message();
        end
    endfunction

    function automatic void check_digest();
        digest_t want;
        if (digest_fifo.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("ERROR %0t: digest beat with none pending: %h %h",
                         $realtime, digest_first, digest_second);
        end
        else
        begin
            want = digest_fifo.pop_front();
            if (digest_first !== want.first || digest_second !== want.second)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("ERROR %0t: digest %0d first exp %h got %h, second exp %h got %h",
                             $realtime, digests_checked, want.first, digest_first,
                             want.second, digest_second);
            end
            digests_checked++;
        end
    endfunction

    // output side first: a digest can never leave on the edge its last beat arrives
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            digests_checked = 0;
            for (int i = 0; i < BLOCK_BYTES; i++)
                block_q[i] = 8'h00;
            start_message();
            digest_fifo.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_digest();
            if (in_valid && in_ready)
                take_beat(data_byte, has_byte, last_item);
        end
        digests_pending = digest_fifo.size();
    end

endmodule

// ===== tb/tb_md5_stream_hash_core.sv =====
// Testbench top for the MD5 stream hash core: clock, reset, beat stimulus and verdict.
module tb_md5_stream_hash_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int HOLD_CYCLES   = 600;      // long output hold-off, fills the core
    localparam int TARGET_BEATS  = 550;
    localparam int CALM_BEATS    = 120;      // closing beats with no idling at all
    localparam int SETTLE_CYCLES = 300;      // > padding pass plus two block compressions
    localparam int TIMEOUT_NS    = 5_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        last_item = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [63:0] digest_first;
    logic [63:0] digest_second;

    int fail_count;
    int digests_pending;
    int digests_checked;

    // stimulus knobs; sink_idle_on and hold_req are shared with the output-side process
    bit gaps_on = 1'b0;
    bit sink_idle_on = 1'b0;
    bit hold_req = 1'b0;

    int beats_sent = 0;
    int messages_sent = 0;
    int longest_msg = 0;

    always #CLK_HALF clk = ~clk;

    md5_stream_hash_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .last_item     (last_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digest_first  (digest_first),
        .digest_second (digest_second)
    );

    md5_stream_checker u_digest_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .last_item       (last_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .digest_first    (digest_first),
        .digest_second   (digest_second),
        .fail_count      (fail_count),
        .digests_pending (digests_pending),
        .digests_checked (digests_checked)
    );

    // Offer one beat and hold it until the core takes it. Valid is left high on
    // return so a following beat goes out back to back; an idle burst, when one
    // is drawn, drops valid first.
    task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= hb;
        last_item <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (lst)
            messages_sent++;
    endtask

    // One message of random bytes. It closes either on its final byte or on a
    // separate byte-less last beat; now and then an ignored beat (no byte, no
    // last) is slipped in ahead of a byte.
    task automatic send_message(input int nbytes);
        bit close_on_byte;
        close_on_byte = (nbytes > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == nbytes - 1));
        end
        if (!close_on_byte)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        if (nbytes > longest_msg)
            longest_msg = nbytes;
    endtask

    // Sender goes quiet until every predicted digest has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digests_pending != 0)
            @(posedge clk);
    endtask

    // Mostly short messages so digests come often; the rest sit around the
    // 55/56 padding split, the 64-byte block edge and the two-block range.
    function automatic int pick_len();
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            len = $urandom_range(0, 12);
        else if (roll < 85)
            len = $urandom_range(52, 72);
        else if (roll < 95)
            len = $urandom_range(110, 130);
        else
        begin
            case ($urandom_range(0, 5))
                0: len = 55;
                1: len = 56;
                2: len = 63;
                3: len = 64;
                4: len = 119;
                default: len = 120;
            endcase
        end
        return len;
    endfunction

    // Output side. Normally ready; while sink idling is on, random stall bursts whose rate
    // changes every so often (a rate of zero gives stretches with no stalls). On a hold
    // request it keeps ready low for a long counted stretch, so finished
    // digests back up and the core has to stall its input.
    initial
    begin
        int stall_pct;
        int slot;
        stall_pct = 10;
        slot = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            slot++;
            if (slot % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Timeout: %0d digests still pending", digests_pending);
        $display("md5_stream_hash_core test failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, with idling on both sides ----
        gaps_on = 1'b1;
        sink_idle_on = 1'b1;
        send_beat(8'h00, 1'b0, 1'b0);     // ignored beat ahead of any message
        send_beat(8'h00, 1'b0, 1'b1);     // empty message
        send_beat(8'h00, 1'b1, 1'b1);     // single zero byte, closed on the byte
        send_beat(8'hff, 1'b1, 1'b1);     // single all-ones byte
        send_beat(8'h61, 1'b1, 1'b0);     // "abc", closed by a byte-less last beat
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b1);
        send_beat(8'ha5, 1'b0, 1'b0);     // ignored beats interleaved with bytes
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h5a, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hc3, 1'b1, 1'b1);
        send_beat(8'hff, 1'b0, 1'b1);     // empty message, stray data must not count
        send_beat(8'h61, 1'b1, 1'b1);
        drain_results();

        // ---- long output hold-off while the sender keeps offering ----
        gaps_on = 1'b0;
        hold_req = 1'b1;
        repeat (4) send_message($urandom_range(0, 3));
        drain_results();

        // ---- random messages; sender idling switched per message ----
        while (beats_sent < TARGET_BEATS - CALM_BEATS)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            send_message(pick_len());
        end

        // ---- closing stretch at full rate on both sides ----
        gaps_on = 1'b0;
        sink_idle_on = 1'b0;
        while (beats_sent < TARGET_BEATS)
            send_message(pick_len());

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d beats over %0d messages (longest random one %0d bytes), %0d digests",
                 beats_sent, messages_sent, longest_msg, digests_checked);
        $display("checked; included block-edge lengths, ignored beats and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("md5_stream_hash_core test passed");
        else
            $display("md5_stream_hash_core test failed");
        $finish;
    end

endmodule

// ===== md5_stream_hash_core.f =====
sv/md5s_pkg.sv
sv/md5s_ram.sv
sv/md5s_round.sv
sv/md5_stream_hash_core.sv
tb/md5_stream_checker.sv
tb/tb_md5_stream_hash_core.sv
